[rtl/pcfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pcfa_pkg
// Shared types, codes and constants of the pair contact force accumulator:
// beat layouts of both channels, configuration fields and arithmetic widths.
// ============================================================================
package pcfa_pkg;

    // Default sizes of the force store.
    localparam int NUM_PARTICLES_DEF = 1024;
    localparam int FORCE_BITS_DEF    = 48;

    // Fixed field widths.
    localparam int INDEX_W   = 10;
    localparam int OUT_W     = 48;
    // With any 16-bit direction pattern a per-axis contribution reaches 2^48 in
    // magnitude, which needs 50 signed bits.
    localparam int CONTRIB_W = 50;
    // Register stages of the contact arithmetic.
    localparam int CALC_LAT  = 5;

    // Operation codes.
    localparam logic [1:0] OP_APPLY = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register map, byte address is four times the index.
    localparam int         APB_ADDR_W    = 4;
    localparam logic [1:0] REG_SPACING   = 2'd0;
    localparam logic [1:0] REG_STIFFNESS = 2'd1;
    localparam logic [1:0] REG_DAMPING   = 2'd2;

    localparam logic [23:0] SPACING_RST   = 24'd65536;
    localparam logic [31:0] STIFFNESS_RST = 32'd65536;
    localparam logic [31:0] DAMPING_RST   = 32'd0;

    typedef struct packed {
        logic [1:0]          op;
        logic [INDEX_W-1:0]  index_first;
        logic [INDEX_W-1:0]  index_second;
        logic                apply_first;
        logic                apply_second;
        logic [23:0]         distance;
        logic signed [15:0]  dir_x;
        logic signed [15:0]  dir_y;
        logic signed [15:0]  dir_z;
        logic signed [31:0]  relvel_x;
        logic signed [31:0]  relvel_y;
        logic signed [31:0]  relvel_z;
    } in_item_t;

    typedef struct packed {
        logic                    in_contact;
        logic signed [OUT_W-1:0] contact_force;
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
    } out_item_t;

    typedef struct packed {
        logic [23:0] contact_spacing;
        logic [31:0] contact_stiffness;
        logic [31:0] contact_damping;
    } cfg_t;

    // Force magnitude and the three per-axis contributions of one pair.
    typedef struct packed {
        logic signed [OUT_W-1:0]     fac;
        logic signed [CONTRIB_W-1:0] cx;
        logic signed [CONTRIB_W-1:0] cy;
        logic signed [CONTRIB_W-1:0] cz;
    } calc_res_t;

endpackage
`default_nettype wire

[rtl/pcfa_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pcfa_cfg_regs
// APB-style configuration registers: contact spacing, stiffness and damping.
// ============================================================================
module pcfa_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pcfa_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output pcfa_pkg::cfg_t                      cfg
);
    import pcfa_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contact_spacing   <= SPACING_RST;
            cfg_reg.contact_stiffness <= STIFFNESS_RST;
            cfg_reg.contact_damping   <= DAMPING_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SPACING:   cfg_reg.contact_spacing   <= pwdata[23:0];
                REG_STIFFNESS: cfg_reg.contact_stiffness <= pwdata;
                REG_DAMPING:   cfg_reg.contact_damping   <= pwdata;
                default:       ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_idx)
            REG_SPACING:   prdata = {8'd0, cfg_reg.contact_spacing};
            REG_STIFFNESS: prdata = cfg_reg.contact_stiffness;
            REG_DAMPING:   prdata = cfg_reg.contact_damping;
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/pcfa_force_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pcfa_force_mem
// Per-particle force store: one write port, one registered read port, and a
// clearing sweep that zeroes every entry after reset.
// ============================================================================
module pcfa_force_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 144
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic                          busy
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             clearing_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic             wen;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;

    // Clearing sweep, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign wen   = clearing_reg || wr_en;
    assign waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign wdata = clearing_reg ? '0 : wr_data;

    // Storage array; a read in the cycle of a write returns the old data.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem_array[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule
`default_nettype wire

[rtl/pcfa_contact_calc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pcfa_contact_calc
// Five-stage contact arithmetic: gap rate, spring and dashpot terms, the
// saturated force magnitude and its three per-axis contributions.
// ============================================================================
module pcfa_contact_calc (
    input  wire logic                clk,
    input  wire pcfa_pkg::in_item_t  item,
    input  wire pcfa_pkg::cfg_t      cfg,
    output pcfa_pkg::calc_res_t      res
);
    import pcfa_pkg::*;

    localparam int RATE_W = 36;
    localparam int SUM4_W = 55;

    // Stage 1 signals.
    logic [23:0]        gap;
    logic [55:0]        spring_full;
    logic signed [47:0] pvx_reg, pvy_reg, pvz_reg;
    logic [39:0]        spring1_reg;
    // Stage 2 signals.
    logic signed [49:0]       rate_sum;
    logic signed [RATE_W-1:0] rate_reg;
    logic [39:0]              spring2_reg;
    // Stage 3 signals.
    logic signed [19:0] rate_hi;
    logic [15:0]        rate_lo;
    logic signed [52:0] dhi_reg;
    logic [47:0]        dlo_reg;
    logic [39:0]        spring3_reg;
    // Stage 4 signals.
    logic signed [SUM4_W-1:0] fac_sum;
    logic signed [OUT_W-1:0]  fac_next;
    logic signed [OUT_W-1:0]  fac_reg;
    // Stage 5 signals.
    logic signed [63:0]           px, py, pz;
    logic signed [OUT_W-1:0]      fac5_reg;
    logic signed [CONTRIB_W-1:0]  cx_reg, cy_reg, cz_reg;

    // Stage 1: velocity by direction products and the spring term.
    assign gap         = cfg.contact_spacing - item.distance;
    assign spring_full = cfg.contact_stiffness * gap;

    always_ff @(posedge clk)
    begin
        pvx_reg     <= item.relvel_x * item.dir_x;
        pvy_reg     <= item.relvel_y * item.dir_y;
        pvz_reg     <= item.relvel_z * item.dir_z;
        spring1_reg <= spring_full[55:16];
    end

    // Stage 2: normal gap rate, floored to Q.16.
    assign rate_sum = 50'(pvx_reg) + 50'(pvy_reg) + 50'(pvz_reg);

    always_ff @(posedge clk)
    begin
        rate_reg    <= RATE_W'(rate_sum >>> 14);
        spring2_reg <= spring1_reg;
    end

    // Stage 3: damping times rate, split into high and low halves of the rate.
    assign rate_hi = rate_reg[RATE_W-1:16];
    assign rate_lo = rate_reg[15:0];

    always_ff @(posedge clk)
    begin
        dhi_reg     <= $signed({1'b0, cfg.contact_damping}) * rate_hi;
        dlo_reg     <= cfg.contact_damping * rate_lo;
        spring3_reg <= spring2_reg;
    end

    // Stage 4: force magnitude, saturated to 48 bits.
    assign fac_sum = SUM4_W'(dhi_reg)
                   + $signed({23'd0, dlo_reg[47:16]})
                   + $signed({15'd0, spring3_reg});

    always_comb
    begin
        if (&fac_sum[SUM4_W-1:OUT_W-1] || ~|fac_sum[SUM4_W-1:OUT_W-1])
        begin
            fac_next = fac_sum[OUT_W-1:0];
        end
        else if (fac_sum[SUM4_W-1])
        begin
            fac_next = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            fac_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        fac_reg <= fac_next;
    end

    // Stage 5: per-axis contributions, floored from Q.30 back to Q.16.
    assign px = fac_reg * item.dir_x;
    assign py = fac_reg * item.dir_y;
    assign pz = fac_reg * item.dir_z;

    always_ff @(posedge clk)
    begin
        fac5_reg <= fac_reg;
        cx_reg   <= CONTRIB_W'(px >>> 14);
        cy_reg   <= CONTRIB_W'(py >>> 14);
        cz_reg   <= CONTRIB_W'(pz >>> 14);
    end

    assign res.fac = fac5_reg;
    assign res.cx  = cx_reg;
    assign res.cy  = cy_reg;
    assign res.cz  = cz_reg;

endmodule
`default_nettype wire

[rtl/pair_contact_force_accumulator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pair_contact_force_accumulator_top
// Linear spring-dashpot contact force between particle pairs, accumulated
// with saturation into a per-particle force store.
// ============================================================================
// The block works on one item at a time. A pair in contact passes from
// acceptance through the contact arithmetic pipeline (three multiply stages
// separated by the rate sum and the magnitude saturation), then a
// read-modify-write step for each of the two particles through the single
// write port of the force store, and a step to load the output register.
// Reads, clears and pairs not in contact skip the arithmetic and the pair
// updates. The result register lets the next item in while the previous
// result still waits for the consumer. After reset the store is zeroed by
// a sweep over every entry, during which in_stall is high; configuration
// writes are taken at any time.
module pair_contact_force_accumulator_top #(
    parameter int NUM_PARTICLES = pcfa_pkg::NUM_PARTICLES_DEF,
    parameter int FORCE_BITS    = pcfa_pkg::FORCE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pcfa_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire pcfa_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output pcfa_pkg::out_item_t                  out_data
);
    import pcfa_pkg::*;

    localparam int AW    = $clog2(NUM_PARTICLES);
    localparam int FB    = FORCE_BITS;
    localparam int MEM_W = 3 * FB;
    localparam int SW    = ((FB > CONTRIB_W) ? FB : CONTRIB_W) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SIMPLE = 3'd1;
    localparam logic [2:0] S_CALC   = 3'd2;
    localparam logic [2:0] S_UPD_I  = 3'd3;
    localparam logic [2:0] S_UPD_J  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    cfg_t       cfg;
    calc_res_t  calc;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       cnt_reg, cnt_next;
    in_item_t         item_reg, item_next;
    logic             contact_reg, contact_next;
    logic [MEM_W-1:0] first_val_reg, first_val_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             mem_busy;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [MEM_W-1:0] mem_rd_data;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [MEM_W-1:0] mem_wr_data;

    logic             in_accept;
    logic             contact_now;
    logic             out_free;
    logic             i_valid, j_valid, same_idx;
    logic [AW-1:0]    addr_i, addr_j;
    logic             wr_i, wr_j;
    logic [MEM_W-1:0] sat_val;
    logic signed [CONTRIB_W-1:0] contrib [3];

    pcfa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcfa_contact_calc u_calc (
        .clk  (clk),
        .item (item_reg),
        .cfg  (cfg),
        .res  (calc)
    );

    pcfa_force_mem #(
        .DEPTH (NUM_PARTICLES),
        .WIDTH (MEM_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .busy    (mem_busy)
    );

    // Handshake and item decode.
    assign in_stall    = (state_reg != S_IDLE) || mem_busy;
    assign in_accept   = in_valid && !in_stall;
    assign contact_now = (in_data.op == OP_APPLY)
                      && (in_data.distance < cfg.contact_spacing);
    assign out_free    = !out_valid_reg || !out_stall;

    assign i_valid  = {22'd0, item_reg.index_first} < 32'(NUM_PARTICLES);
    assign j_valid  = {22'd0, item_reg.index_second} < 32'(NUM_PARTICLES);
    assign same_idx = item_reg.index_first == item_reg.index_second;
    assign addr_i   = AW'(item_reg.index_first);
    assign addr_j   = AW'(item_reg.index_second);
    assign wr_i     = item_reg.apply_first && i_valid;
    assign wr_j     = item_reg.apply_second && j_valid;

    assign contrib[0] = calc.cx;
    assign contrib[1] = calc.cy;
    assign contrib[2] = calc.cz;

    // Saturating accumulate, shared by both updates of a pair. The second
    // update subtracts and sees the first one's result when indices match.
    always_comb
    begin
        logic [MEM_W-1:0]            base;
        logic signed [FB-1:0]        base_a;
        logic signed [CONTRIB_W-1:0] add_a;
        logic signed [SW-1:0]        sum_a;
        if (state_reg == S_UPD_J && same_idx)
        begin
            base = first_val_reg;
        end
        else
        begin
            base = mem_rd_data;
        end
        for (int a = 0; a < 3; a++)
        begin
            base_a = base[a*FB +: FB];
            add_a  = (state_reg == S_UPD_J) ? -contrib[a] : contrib[a];
            sum_a  = SW'(base_a) + SW'(add_a);
            if (&sum_a[SW-1:FB-1] || ~|sum_a[SW-1:FB-1])
            begin
                sat_val[a*FB +: FB] = sum_a[FB-1:0];
            end
            else if (sum_a[SW-1])
            begin
                sat_val[a*FB +: FB] = {1'b1, {(FB-1){1'b0}}};
            end
            else
            begin
                sat_val[a*FB +: FB] = {1'b0, {(FB-1){1'b1}}};
            end
        end
    end

    // Sequencer: accept, arithmetic and store updates or read and clear, result.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        item_next      = item_reg;
        contact_next   = contact_reg;
        first_val_next = first_val_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = AW'(in_data.index_first);
        mem_wr_en      = 1'b0;
        mem_wr_addr    = addr_i;
        mem_wr_data    = sat_val;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    item_next    = in_data;
                    contact_next = contact_now;
                    cnt_next     = '0;
                    mem_rd_en    = 1'b1;
                    state_next   = contact_now ? S_CALC : S_SIMPLE;
                end
            end
            S_SIMPLE:
            begin
                if (item_reg.op == OP_CLEAR && i_valid)
                begin
                    mem_wr_en      = 1'b1;
                    mem_wr_data    = '0;
                    first_val_next = '0;
                end
                else
                begin
                    first_val_next = i_valid ? mem_rd_data : '0;
                end
                state_next = S_DONE;
            end
            S_CALC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(CALC_LAT - 1))
                begin
                    state_next = S_UPD_I;
                end
            end
            S_UPD_I:
            begin
                mem_wr_en = wr_i;
                if (!i_valid)
                begin
                    first_val_next = '0;
                end
                else if (item_reg.apply_first)
                begin
                    first_val_next = sat_val;
                end
                else
                begin
                    first_val_next = mem_rd_data;
                end
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_j;
                state_next  = S_UPD_J;
            end
            S_UPD_J:
            begin
                mem_wr_en   = wr_j;
                mem_wr_addr = addr_j;
                if (wr_j && same_idx)
                begin
                    first_val_next = sat_val;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.in_contact    = contact_reg;
                    out_data_next.contact_force = contact_reg ? calc.fac : '0;
                    out_data_next.force_x       = OUT_W'($signed(first_val_reg[0*FB +: FB]));
                    out_data_next.force_y       = OUT_W'($signed(first_val_reg[1*FB +: FB]));
                    out_data_next.force_z       = OUT_W'($signed(first_val_reg[2*FB +: FB]));
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        contact_reg   <= contact_next;
        first_val_reg <= first_val_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The sequencer stays idle while the store is being cleared.
    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> state_reg == S_IDLE)
        else $error("item in flight during store clearing");

    // Only a pair in contact enters the arithmetic wait.
    a_calc_only_contact: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC |-> contact_reg && cnt_reg <= 3'(CALC_LAT - 1))
        else $error("arithmetic wait entered without contact");

    // The update of the first particle is always followed by the second one.
    a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD_I |=> state_reg == S_UPD_J)
        else $error("pair update sequence broken");

    // The store is written only in the update and clear steps.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_UPD_I || state_reg == S_UPD_J
                       || state_reg == S_SIMPLE))
        else $error("force store written outside an update step");

endmodule
`default_nettype wire
